// ----- rtl/ffra_pkg.sv -----
package ffra_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned DEFAULT_WORD_BYTES = 4;
  localparam int unsigned DEFAULT_MAX_SECTIONS = 64;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_REGION_START = 1'b0,
    REG_REGION_END   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_end;
    logic              region_ok;
  } region_t;

endpackage

// ----- rtl/ffra_table.sv -----
module ffra_table #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  ffra_pkg::entry_t wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output ffra_pkg::entry_t rdata_o
);
  import ffra_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ffra_ctrl.sv -----
module ffra_ctrl #(
  parameter int unsigned WordBytes   = 4,
  parameter int unsigned MaxSections = 64,
  parameter int unsigned IdxW        = 6,
  parameter int unsigned CntW        = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       init_i,
  input  ffra_pkg::region_t          region_i,
  input  logic                       start_i,
  input  ffra_pkg::in_item_t         item_i,
  output logic                       idle_o,
  output logic                       done_o,
  input  logic                       take_i,
  output ffra_pkg::out_item_t        result_o,
  output logic                       tbl_we_o,
  output logic [IdxW-1:0]            tbl_waddr_o,
  output ffra_pkg::entry_t           tbl_wdata_o,
  output logic [IdxW-1:0]            tbl_raddr_o,
  input  ffra_pkg::entry_t           tbl_rdata_i
);
  import ffra_pkg::*;

  localparam logic [ADDR_W-1:0] Hdr = ADDR_W'(2 * WordBytes);
  // Word size is a power of two, so the remainder is a mask of the low bits.
  localparam logic [ADDR_W-1:0] WordMask = ADDR_W'(WordBytes - 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSections);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_START = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_RD    = 13'b0000000001000,
    S_EVAL  = 13'b0000000010000,
    S_SHRD  = 13'b0000000100000,
    S_SHWR  = 13'b0000001000000,
    S_INS   = 13'b0000010000000,
    S_FRD   = 13'b0000100000000,
    S_FEVAL = 13'b0001000000000,
    S_FSHRD = 13'b0010000000000,
    S_FSHWR = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ADDR_W-1:0] head_size_q, head_size_d;
  in_item_t          item_q, item_d;
  logic [ADDR_W-1:0] total_q, total_d;
  logic [ADDR_W:0]   nb_q, nb_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   j_q, j_d;
  logic [ADDR_W-1:0] p_q, p_d;
  out_item_t         res_q, res_d;

  logic [ADDR_W-1:0] word_rem;
  logic [ADDR_W+1:0] req_tot;
  logic [ADDR_W+1:0] gap_end;
  logic [ADDR_W-1:0] lim;
  logic [ADDR_W-1:0] p_calc;
  logic              has_next;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_size_d = head_size_q;
    item_d      = item_q;
    total_d     = total_q;
    nb_d        = nb_q;
    idx_d       = idx_q;
    j_d         = j_q;
    p_d         = p_q;
    res_d       = res_q;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = '0;
    tbl_wdata_o = '0;
    tbl_raddr_o = '0;

    word_rem = item_q.request_size & WordMask;
    req_tot  = {2'b00, item_q.request_size}
             + ((word_rem != '0) ? {2'b00, ADDR_W'(WordBytes) - word_rem} : '0)
             + {2'b00, Hdr};
    gap_end  = {1'b0, nb_q} + {2'b00, total_q};
    has_next = (idx_q + 1'b1) < count_q;
    lim      = has_next ? tbl_rdata_i.base : region_i.region_end;
    p_calc   = item_i.block_address - Hdr;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d  = item_i;
          p_d     = p_calc;
          state_d = S_START;
        end
      end
      S_START: begin
        if (item_q.command == CMD_FREE) begin
          if (!region_i.region_ok || p_q < region_i.region_start ||
              p_q >= region_i.region_end) begin
            res_d   = '{result_address: '0, status: ST_IGNORED};
            state_d = S_DONE;
          end else if (p_q == region_i.region_start) begin
            res_d = '{result_address: '0,
                      status: (head_size_q == '0) ? ST_IGNORED : ST_OK};
            head_size_d = '0;
            state_d     = S_DONE;
          end else begin
            j_d     = CntW'(1);
            state_d = S_FRD;
          end
        end else if (item_q.request_size == '0) begin
          res_d   = '{result_address: '0, status: ST_ZERO_SIZE};
          state_d = S_DONE;
        end else if (!region_i.region_ok) begin
          res_d   = '{result_address: '0, status: ST_NO_SPACE};
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (req_tot[ADDR_W+1:ADDR_W] != 2'b00) begin
          res_d   = '{result_address: '0, status: ST_NO_SPACE};
          state_d = S_DONE;
        end else begin
          total_d = req_tot[ADDR_W-1:0];
          nb_d    = {1'b0, region_i.region_start} + {1'b0, head_size_q};
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        tbl_raddr_o = IdxW'(idx_q + 1'b1);
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (gap_end[ADDR_W+1:ADDR_W] != 2'b00) begin
          res_d   = '{result_address: '0, status: ST_NO_SPACE};
          state_d = S_DONE;
        end else if (gap_end[ADDR_W-1:0] <= lim) begin
          if (idx_q == '0 && head_size_q == '0) begin
            head_size_d = total_q;
            res_d   = '{result_address: nb_q[ADDR_W-1:0] + Hdr, status: ST_OK};
            state_d = S_DONE;
          end else if (count_q >= MaxCnt) begin
            res_d   = '{result_address: '0, status: ST_FULL};
            state_d = S_DONE;
          end else begin
            j_d     = count_q;
            state_d = (count_q > idx_q + 1'b1) ? S_SHRD : S_INS;
          end
        end else if (!has_next) begin
          res_d   = '{result_address: '0, status: ST_NO_SPACE};
          state_d = S_DONE;
        end else begin
          nb_d    = {1'b0, tbl_rdata_i.base} + {1'b0, tbl_rdata_i.size};
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      // open a slot: move entries up, highest first
      S_SHRD: begin
        tbl_raddr_o = IdxW'(j_q - 1'b1);
        state_d     = S_SHWR;
      end
      S_SHWR: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = IdxW'(j_q);
        tbl_wdata_o = tbl_rdata_i;
        j_d         = j_q - 1'b1;
        state_d     = ((j_q - 1'b1) > idx_q + 1'b1) ? S_SHRD : S_INS;
      end
      S_INS: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = IdxW'(idx_q + 1'b1);
        tbl_wdata_o = '{base: nb_q[ADDR_W-1:0], size: total_q};
        count_d     = count_q + 1'b1;
        res_d       = '{result_address: nb_q[ADDR_W-1:0] + Hdr, status: ST_OK};
        state_d     = S_DONE;
      end
      S_FRD: begin
        tbl_raddr_o = IdxW'(j_q);
        if (j_q >= count_q) begin
          res_d   = '{result_address: '0, status: ST_IGNORED};
          state_d = S_DONE;
        end else begin
          state_d = S_FEVAL;
        end
      end
      S_FEVAL: begin
        if (tbl_rdata_i.base == p_q) begin
          state_d = S_FSHRD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_FRD;
        end
      end
      // close the gap: move entries down, lowest first
      S_FSHRD: begin
        tbl_raddr_o = IdxW'(j_q + 1'b1);
        if ((j_q + 1'b1) < count_q) begin
          state_d = S_FSHWR;
        end else begin
          count_d = count_q - 1'b1;
          res_d   = '{result_address: '0, status: ST_OK};
          state_d = S_DONE;
        end
      end
      S_FSHWR: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = IdxW'(j_q);
        tbl_wdata_o = tbl_rdata_i;
        j_d         = j_q + 1'b1;
        state_d     = S_FSHRD;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (init_i) begin
      count_d     = CntW'(1);
      head_size_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CntW'(1);
      head_size_q <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_size_q <= head_size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    total_q <= total_d;
    nb_q    <= nb_d;
    idx_q   <= idx_d;
    j_q     <= j_d;
    p_q     <= p_d;
    res_q   <= res_d;
  end

  assign idle_o   = (state_q == S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign result_o = res_q;

endmodule

// ----- rtl/first_fit_region_allocator_top.sv -----
// Sequence: an allocate checks the request and rounds it to whole words, walks the
//   sections, and to add an entry moves later entries up and then writes it. A free
//   ends at once on the head or outside the region, else it searches the sections and
//   moves later entries down; the result then moves to the output once that is free.
// Throughput: one item at a time; the next item enters once the result is in the
//   output register. The section table's registered read sets the per-section cost.
// Reset: asynchronous, active low; the region reads zero and the table holds one empty head.
module first_fit_region_allocator_top #(
  parameter int unsigned WordBytes   = ffra_pkg::DEFAULT_WORD_BYTES,
  parameter int unsigned MaxSections = ffra_pkg::DEFAULT_MAX_SECTIONS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffra_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffra_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  ffra_pkg::cfg_reg_e  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import ffra_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSections);
  localparam int unsigned CntW = $clog2(MaxSections + 1);
  localparam logic [ADDR_W:0] HdrWide = (ADDR_W+1)'(2 * WordBytes);

  logic [ADDR_W-1:0] start_q, end_q;
  logic              cfg_write;
  region_t           region;

  logic       idle, done, take;
  out_item_t  result;
  logic       out_valid_q;
  out_item_t  out_q;

  logic            tbl_we;
  logic [IdxW-1:0] tbl_waddr, tbl_raddr;
  entry_t          tbl_wdata, tbl_rdata;

  // Config only lands while idle; any write rebuilds the table.
  assign cfg_ready_o = idle;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        REG_REGION_START: start_q <= cfg_data_i;
        REG_REGION_END:   end_q   <= cfg_data_i;
        default:          start_q <= start_q;
      endcase
    end
  end

  // The region is usable when it is ordered and holds at least one header.
  assign region.region_start = start_q;
  assign region.region_end   = end_q;
  assign region.region_ok    = (start_q <= end_q) &&
                               (({1'b0, end_q} - {1'b0, start_q}) >= HdrWide);

  // Accept a new item only when the sequencer is idle.
  assign in_stall_o = !idle;

  // Move the finished result into the output register when it is free or draining.
  assign take = done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ffra_ctrl #(
    .WordBytes  (WordBytes),
    .MaxSections(MaxSections),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (cfg_write),
    .region_i   (region),
    .start_i    (in_valid_i && !in_stall_o),
    .item_i     (in_data_i),
    .idle_o     (idle),
    .done_o     (done),
    .take_i     (take),
    .result_o   (result),
    .tbl_we_o   (tbl_we),
    .tbl_waddr_o(tbl_waddr),
    .tbl_wdata_o(tbl_wdata),
    .tbl_raddr_o(tbl_raddr),
    .tbl_rdata_i(tbl_rdata)
  );

  // Entries 1 and up; the head lives in the sequencer at the region start.
  ffra_table #(
    .Depth(MaxSections),
    .IdxW (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

endmodule

// ----- rtl/ffra_checker.sv -----
module ffra_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ffra_pkg::out_item_t out_data_o,
  input logic                cfg_ready_o
);
  import ffra_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("block not busy after taking an item");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !in_stall_o)
    else $error("config ready and input stall disagree");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.result_address == '0)
    else $error("failed item carries an address");

endmodule

bind first_fit_region_allocator_top ffra_checker u_ffra_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_ready_o(cfg_ready_o)
);
